>>> hdl/rmsb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rmsb_pkg;

    localparam int DEF_COUNT_WIDTH = 32;
    localparam int DEF_FRAC_BITS   = 16;

    // widths sized for the largest fraction setting (24 bits)
    localparam int SAMPLE_W = 31;
    localparam int XF_W     = 55;
    localparam int D_W      = 57;
    localparam int MAG_W    = 56;
    localparam int MEAN_W   = 48;
    localparam int M2_W     = 64;
    localparam int ALU_W    = 66;
    localparam int STEP_W   = 7;

    localparam logic [STEP_W-1:0] DIV_STEPS  = STEP_W'(64);
    localparam logic [STEP_W-1:0] SQRT_STEPS = STEP_W'(32);
    localparam logic [STEP_W-1:0] MUL_STEPS  = STEP_W'(MAG_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_MEAN,
        S_MEAN,
        S_MUL,
        S_M2,
        S_DIV_VAR,
        S_SQRT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

endpackage
`default_nettype wire

>>> hdl/rmsb_addsub.sv
`timescale 1ns / 1ps
`default_nettype none
module rmsb_addsub
    import rmsb_pkg::*;
(
    input  wire alu_req_t         req,
    output logic [ALU_W-1:0]      y
);

    always_comb begin
        if (req.sub) begin
            y = req.a - req.b;
        end else begin
            y = req.a + req.b;
        end
    end

endmodule
`default_nettype wire

>>> hdl/running_mean_stddev_bound_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// sequence: an accepted sample runs 64 divide steps for the mean, the mean update (S_MEAN),
//   56 multiply steps, the sum update (S_M2), 64 divide steps for the variance, 32 root steps
//   and S_DONE; while at most one sample has been seen, the variance divide is skipped
// no new sample is taken until S_DONE is left; divide, multiply and root steps share one add/subtract unit
// the result register frees the input side, a new sample is taken while a result waits
// reset: synchronous active-low aresetn clears count, mean, squared-deviation sum, state and output valid
module running_mean_stddev_bound_unit
    import rmsb_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // [30:0] sample_ns
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [63:0] m_tdata    // [30:0] bound_ns, [61:31] mean_ns
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic signed [57:0] MEAN_HI = 58'sh0007FFFFFFFFFFF;
    localparam logic signed [57:0] MEAN_LO = -58'sh000800000000000;

    state_t state_reg, state_next;
    logic [STEP_W-1:0]             step_reg, step_next;
    logic [COUNT_WIDTH-1:0]        count_reg, count_next;
    logic signed [MEAN_W-1:0]      mean_reg, mean_next;
    logic [M2_W-1:0]               m2_reg, m2_next;
    logic signed [XF_W-1:0]        xf_reg, xf_next;
    logic                          dneg_reg, dneg_next;
    logic                          eneg_reg, eneg_next;
    logic [MAG_W-1:0]              dmag_reg, dmag_next;
    logic [63:0]                   dvd_reg, dvd_next;
    logic [COUNT_WIDTH:0]          rem_reg, rem_next;
    logic [COUNT_WIDTH-1:0]        div_reg, div_next;
    logic [MAG_W:0]                hi_reg, hi_next;
    logic [MAG_W-1:0]              lo_reg, lo_next;
    logic [63:0]                   v_reg, v_next;
    logic [63:0]                   res_reg, res_next;
    logic [63:0]                   bit_reg, bit_next;
    logic                          mvalid_reg, mvalid_next;
    logic [63:0]                   mdata_reg, mdata_next;

    alu_req_t          alu_req;
    logic [ALU_W-1:0]  alu_y;

    logic signed [XF_W-1:0]  xf_in;
    logic [COUNT_WIDTH-1:0]  n_in;
    logic signed [D_W-1:0]   d_in;
    logic [COUNT_WIDTH:0]    rem_sh;
    logic                    ge;
    logic signed [57:0]      step_s, mean_sum;
    logic signed [MEAN_W-1:0] mean_new;
    logic signed [D_W-1:0]   e_val;
    logic [MAG_W:0]          mul_acc;
    logic [2*MAG_W-1:0]      prod, prod_sh;
    logic [M2_W-1:0]         term, m2_upd;
    logic [M2_W:0]           m2_sum;
    logic [63:0]             rb;
    logic signed [57:0]      bound;
    logic [57:0]             bound_sh;
    logic [30:0]             bound_ns;
    logic [MEAN_W:0]         mean_abs, mean_abs_sh;
    logic [30:0]             mean_ns;

    rmsb_addsub u_alu (
        .req (alu_req),
        .y   (alu_y)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            mean_reg   <= '0;
            m2_reg     <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            mean_reg   <= mean_next;
            m2_reg     <= m2_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg  <= step_next;
        xf_reg    <= xf_next;
        dneg_reg  <= dneg_next;
        eneg_reg  <= eneg_next;
        dmag_reg  <= dmag_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        v_reg     <= v_next;
        res_reg   <= res_next;
        bit_reg   <= bit_next;
        mdata_reg <= mdata_next;
    end

    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        count_next  = count_reg;
        mean_next   = mean_reg;
        m2_next     = m2_reg;
        xf_next     = xf_reg;
        dneg_next   = dneg_reg;
        eneg_next   = eneg_reg;
        dmag_next   = dmag_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        v_next      = v_reg;
        res_next    = res_reg;
        bit_next    = bit_reg;
        mdata_next  = mdata_reg;
        mvalid_next = mvalid_reg && !m_tready;

        alu_req = '0;

        xf_in = $signed({{(XF_W-SAMPLE_W){s_tdata[30]}}, s_tdata[30:0]}) <<< FRAC_BITS;
        n_in  = (count_reg == CNT_MAX) ? count_reg : count_reg + 1'b1;
        d_in  = D_W'(xf_in) - D_W'(mean_reg);

        rem_sh = {rem_reg[COUNT_WIDTH-1:0], dvd_reg[63]};
        ge     = !alu_y[ALU_W-1];

        step_s   = dneg_reg ? -$signed(58'(dvd_reg[MAG_W-1:0]))
                            : $signed(58'(dvd_reg[MAG_W-1:0]));
        mean_sum = 58'(mean_reg) + step_s;
        if (mean_sum > MEAN_HI) begin
            mean_new = MEAN_HI[MEAN_W-1:0];
        end else if (mean_sum < MEAN_LO) begin
            mean_new = MEAN_LO[MEAN_W-1:0];
        end else begin
            mean_new = mean_sum[MEAN_W-1:0];
        end
        e_val = D_W'(xf_reg) - D_W'(mean_new);

        mul_acc = lo_reg[0] ? alu_y[MAG_W:0] : hi_reg;

        prod    = {hi_reg[MAG_W-1:0], lo_reg};
        prod_sh = prod >> FRAC_BITS;
        term    = (|prod_sh[2*MAG_W-1:M2_W]) ? {M2_W{1'b1}} : prod_sh[M2_W-1:0];
        m2_sum  = {1'b0, m2_reg} + {1'b0, term};
        if (dneg_reg == eneg_reg) begin
            m2_upd = m2_sum[M2_W] ? {M2_W{1'b1}} : m2_sum[M2_W-1:0];
        end else begin
            m2_upd = (term > m2_reg) ? '0 : m2_reg - term;
        end

        rb = res_reg | bit_reg;

        bound    = 58'(mean_reg) + $signed(58'(res_reg[31:0]) << FRAC_BITS);
        bound_sh = 58'(bound) >> FRAC_BITS;
        if (bound <= 0) begin
            bound_ns = '0;
        end else if (|bound_sh[57:31]) begin
            bound_ns = {31{1'b1}};
        end else begin
            bound_ns = bound_sh[30:0];
        end
        mean_abs    = mean_reg[MEAN_W-1] ? -(MEAN_W+1)'(mean_reg) : (MEAN_W+1)'(mean_reg);
        mean_abs_sh = mean_abs >> FRAC_BITS;
        mean_ns     = mean_reg[MEAN_W-1] ? -mean_abs_sh[30:0] : mean_abs_sh[30:0];

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    count_next = n_in;
                    xf_next    = xf_in;
                    dneg_next  = d_in[D_W-1];
                    dmag_next  = d_in[D_W-1] ? MAG_W'(-d_in) : MAG_W'(d_in);
                    dvd_next   = 64'(d_in[D_W-1] ? MAG_W'(-d_in) : MAG_W'(d_in));
                    rem_next   = '0;
                    div_next   = n_in;
                    step_next  = DIV_STEPS;
                    state_next = S_DIV_MEAN;
                end
            end
            S_DIV_MEAN, S_DIV_VAR: begin
                alu_req.a   = ALU_W'(rem_sh);
                alu_req.b   = ALU_W'(div_reg);
                alu_req.sub = 1'b1;
                rem_next    = ge ? alu_y[COUNT_WIDTH:0] : rem_sh;
                dvd_next    = {dvd_reg[62:0], ge};
                step_next   = step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    if (state_reg == S_DIV_MEAN) begin
                        state_next = S_MEAN;
                    end else begin
                        v_next     = {dvd_reg[62:0], ge} >> FRAC_BITS;
                        res_next   = '0;
                        bit_next   = 64'h4000_0000_0000_0000;
                        step_next  = SQRT_STEPS;
                        state_next = S_SQRT;
                    end
                end
            end
            S_MEAN: begin
                mean_next  = mean_new;
                eneg_next  = e_val[D_W-1];
                hi_next    = '0;
                lo_next    = e_val[D_W-1] ? MAG_W'(-e_val) : MAG_W'(e_val);
                step_next  = MUL_STEPS;
                state_next = S_MUL;
            end
            S_MUL: begin
                // shift-add, one multiplier bit per cycle
                alu_req.a   = ALU_W'(hi_reg);
                alu_req.b   = ALU_W'(dmag_reg);
                alu_req.sub = 1'b0;
                {hi_next, lo_next} = {mul_acc, lo_reg} >> 1;
                step_next   = step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    state_next = S_M2;
                end
            end
            S_M2: begin
                m2_next = m2_upd;
                if (count_reg > COUNT_WIDTH'(1)) begin
                    dvd_next   = m2_upd;
                    rem_next   = '0;
                    div_next   = count_reg - 1'b1;
                    step_next  = DIV_STEPS;
                    state_next = S_DIV_VAR;
                end else begin
                    v_next     = '0;
                    res_next   = '0;
                    bit_next   = 64'h4000_0000_0000_0000;
                    step_next  = SQRT_STEPS;
                    state_next = S_SQRT;
                end
            end
            S_SQRT: begin
                alu_req.a   = ALU_W'(v_reg);
                alu_req.b   = ALU_W'(rb);
                alu_req.sub = 1'b1;
                if (ge) begin
                    v_next   = alu_y[63:0];
                    res_next = (res_reg >> 1) | bit_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next  = bit_reg >> 2;
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!mvalid_reg || m_tready) begin
                    mdata_next  = {2'b00, mean_ns, bound_ns};
                    mvalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a transaction is in progress");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the final step");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (count_reg != '0))
        else $error("sample count zero after a transaction");

    a_root_width: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) |-> (res_reg[63:32] == '0))
        else $error("square root wider than 32 bits");

endmodule
`default_nettype wire
